>>> hw/rtl/sdf_pkg.sv
// shared types, character codes and control store for the decimal field formatter
package sdf_pkg;

  // default field capacity in characters
  localparam int MAX_FIELD_DEF = 8;

  // width of field_width + frac_digits, and of the signed position compares
  localparam int SUM_W = 5;
  localparam int CMP_W = 6;

  // reciprocal of ten for a 16-bit magnitude: q = (x * RECIP10) >> RECIP_SH
  localparam logic [15:0] RECIP10  = 16'hCCCD;
  localparam int          RECIP_SH = 19;

  // character codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_POINT = 7'h2E;
  localparam logic [6:0] CH_ERROR = 7'h3F;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIGIT,
    OP_SIGN,
    OP_SET_OVF,
    OP_ERROR,
    OP_EMIT
  } op_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_XFER,
    C_ILLEGAL,
    C_DIGITS_DONE,
    C_POS_NEG,
    C_OUT_LAST
  } cond_t;

  // microprogram steps
  typedef enum logic [3:0] {
    ST_WAIT,
    ST_CHECK,
    ST_TEST,
    ST_ROOM,
    ST_DIGIT,
    ST_SIGN,
    ST_FULL,
    ST_ERR,
    ST_EMIT
  } step_t;

  // one control word: operation, branch condition, targets when true and false
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t yes;
    step_t no;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_xfer;
    logic illegal;
    logic digits_done;
    logic pos_neg;
    logic out_last;
  } status_t;

  // control store
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    unique case (step)
      ST_WAIT:  w = '{op: OP_LOAD,    cond: C_IN_XFER,     yes: ST_CHECK, no: ST_WAIT};
      ST_CHECK: w = '{op: OP_NOP,     cond: C_ILLEGAL,     yes: ST_ERR,   no: ST_TEST};
      ST_TEST:  w = '{op: OP_NOP,     cond: C_DIGITS_DONE, yes: ST_SIGN,  no: ST_ROOM};
      ST_ROOM:  w = '{op: OP_NOP,     cond: C_POS_NEG,     yes: ST_FULL,  no: ST_DIGIT};
      ST_DIGIT: w = '{op: OP_DIGIT,   cond: C_ALWAYS,      yes: ST_TEST,  no: ST_TEST};
      ST_SIGN:  w = '{op: OP_SIGN,    cond: C_ALWAYS,      yes: ST_EMIT,  no: ST_EMIT};
      ST_FULL:  w = '{op: OP_SET_OVF, cond: C_ALWAYS,      yes: ST_SIGN,  no: ST_SIGN};
      ST_ERR:   w = '{op: OP_ERROR,   cond: C_ALWAYS,      yes: ST_EMIT,  no: ST_EMIT};
      ST_EMIT:  w = '{op: OP_EMIT,    cond: C_OUT_LAST,    yes: ST_WAIT,  no: ST_EMIT};
      default:  w = '{op: OP_NOP,     cond: C_ALWAYS,      yes: ST_WAIT,  no: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/sdf_sequencer.sv
// step counter, control store lookup and conditional branching
module sdf_sequencer
  import sdf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t step;
  step_t step_next;
  logic  cond_true;

  // control word for the current step
  assign ctrl = ucode_rom(step);

  // branch condition select
  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:      cond_true = 1'b1;
      C_IN_XFER:     cond_true = status.in_xfer;
      C_ILLEGAL:     cond_true = status.illegal;
      C_DIGITS_DONE: cond_true = status.digits_done;
      C_POS_NEG:     cond_true = status.pos_neg;
      C_OUT_LAST:    cond_true = status.out_last;
      default:       cond_true = 1'b1;
    endcase
    step_next = cond_true ? ctrl.yes : ctrl.no;
  end

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> hw/rtl/sdf_datapath.sv
// magnitude, position and character buffer registers driven by the control word
module sdf_datapath
  import sdf_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  op_t                op,
  input  logic               in_xfer,
  input  logic               out_xfer,
  input  logic signed [15:0] number,
  input  logic [3:0]         field_width,
  input  logic [2:0]         frac_digits,
  output status_t            status,
  output logic [6:0]         char_code,
  output logic               last_char,
  output logic               overflow
);

  localparam int IW = $clog2(MAX_FIELD);
  localparam int PW = IW + 1;

  logic [15:0]          mag;
  logic                 neg;
  logic [3:0]           w;
  logic [2:0]           p;
  logic [SUM_W-1:0]     sum;
  logic signed [PW-1:0] pos;
  logic                 ovf;
  logic [IW-1:0]        k;
  logic [6:0]           char_buf [MAX_FIELD];

  logic [SUM_W-1:0]      sum_in;
  logic signed [CMP_W-1:0] pos_x;
  logic signed [CMP_W-1:0] w_x;
  logic                  at_point;
  logic [IW-1:0]         idx0;
  logic [IW-1:0]         idx1;
  logic [31:0]           prod;
  logic [12:0]           quot;
  logic [15:0]           times10;
  logic [15:0]           rem;
  logic [6:0]            digit;

  assign sum_in = SUM_W'(field_width) + SUM_W'(frac_digits);

  // signed position compares against the width
  assign pos_x    = CMP_W'(pos);
  assign w_x      = $signed({{(CMP_W - 4){1'b0}}, w});
  assign at_point = (p != 3'd0) && (pos_x == w_x - signed'(CMP_W'(1)));
  assign idx0     = pos[IW-1:0];
  assign idx1     = idx0 - 1'b1;

  // divide by ten through the reciprocal, remainder as the digit
  assign prod    = {16'b0, mag} * {16'b0, RECIP10};
  assign quot    = prod[31:RECIP_SH];
  assign times10 = 16'({quot, 3'b0}) + 16'({quot, 1'b0});
  assign rem     = mag - times10;
  assign digit   = CH_ZERO + 7'(rem[3:0]);

  // status for the sequencer
  assign status.in_xfer     = in_xfer;
  assign status.illegal     = (w == 4'd0) || (sum > SUM_W'(MAX_FIELD))
                              || ((p != 3'd0) && (w < 4'd2));
  assign status.digits_done = (mag == 16'd0) && !(pos_x > w_x - signed'(CMP_W'(2)));
  assign status.pos_neg     = pos[PW-1];
  assign status.out_last    = out_xfer && last_char;

  // output fields
  assign char_code = char_buf[k];
  assign last_char = (SUM_W'(k) + SUM_W'(1)) == sum;
  assign overflow  = ovf;

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
      k   <= '0;
    end else begin
      unique case (op)
        OP_LOAD: begin
          if (in_xfer) begin
            neg <= number[15];
            mag <= number[15] ? 16'(~number + 16'sd1) : 16'(number);
            w   <= field_width;
            p   <= frac_digits;
            sum <= sum_in;
            pos <= PW'(sum_in - SUM_W'(1));
            ovf <= 1'b0;
            k   <= '0;
            for (int i = 0; i < MAX_FIELD; i++) begin
              char_buf[i] <= CH_SPACE;
            end
          end
        end
        OP_DIGIT: begin
          mag <= {3'b0, quot};
          if (at_point) begin
            char_buf[idx0] <= CH_POINT;
            char_buf[idx1] <= digit;
            pos            <= pos - PW'(2);
          end else begin
            char_buf[idx0] <= digit;
            pos            <= pos - PW'(1);
          end
        end
        OP_SIGN: begin
          if (!pos[PW-1]) begin
            char_buf[idx0] <= neg ? CH_MINUS : CH_SPACE;
          end else if (neg) begin
            ovf <= 1'b1;
          end
        end
        OP_SET_OVF: begin
          ovf <= 1'b1;
        end
        OP_ERROR: begin
          char_buf[0] <= CH_ERROR;
          ovf         <= 1'b1;
          sum         <= SUM_W'(1);
        end
        OP_EMIT: begin
          if (out_xfer) begin
            k <= k + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/signed_decimal_field_formatter.sv
// top level: signed decimal field formatter, sequencer plus datapath
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    number, field_width, frac_digits
//  out      output     out_valid / out_ready  char_code, last_char, overflow
//
// one item at a time; in_ready is high only while the sequencer waits for input
// each item passes the wait and check steps, three control steps per digit (test, room, digit),
//   a full step when high-order digits are dropped, the sign step, then the emit step for its characters
// an illegal size passes the wait, check and error steps before the single error character
// rst is synchronous and returns the sequencer to its wait step
// out_ready low holds the current character; nothing is lost or repeated
module signed_decimal_field_formatter
  import sdf_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] number,
  input  logic [3:0]         field_width,
  input  logic [2:0]         frac_digits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         char_code,
  output logic               last_char,
  output logic               overflow
);

  ctrl_t   ctrl;
  status_t status;
  logic    in_xfer;
  logic    out_xfer;

  // handshakes follow the current control word
  assign in_ready  = (ctrl.op == OP_LOAD);
  assign out_valid = (ctrl.op == OP_EMIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // control sequencer
  sdf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // datapath
  sdf_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (ctrl.op),
    .in_xfer     (in_xfer),
    .out_xfer    (out_xfer),
    .number      (number),
    .field_width (field_width),
    .frac_digits (frac_digits),
    .status      (status),
    .char_code   (char_code),
    .last_char   (last_char),
    .overflow    (overflow)
  );

`ifndef SYNTHESIS
  // input and output never open at once
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output handshakes open together");

  // an accepted item is never answered in the next cycle
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> !out_valid)
    else $error("result shown right after input transfer");

  // the error character is always a single flagged result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == CH_ERROR) |-> (last_char && overflow))
    else $error("error character without last and overflow");

  // the final character returns the block to waiting for input
  assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_char) |=> in_ready)
    else $error("not ready for input after last character");
`endif

endmodule

>>> tb/sdf_field_checker.sv
// checker for the decimal field formatter: predicts each field and compares the characters
`timescale 1ns / 1ps

module sdf_field_checker
  import sdf_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] number,
  input  logic [3:0]         field_width,
  input  logic [2:0]         frac_digits,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [6:0]         char_code,
  input  logic               last_char,
  input  logic               overflow,
  output int                 errors,
  output int                 chars_outstanding
);

  // one character of a formatted field
  typedef struct packed {
    logic [6:0] code;
    logic       last;
    logic       ovf;
  } field_char_t;

  field_char_t expected_chars[$];
  int          fail_count = 0;
  int          outstanding = 0;

  assign errors            = fail_count;
  assign chars_outstanding = outstanding;

  // print one line per mismatch (capped) and count every one
  task automatic report_mismatch(input string what, input logic [6:0] got,
                                 input logic [6:0] want);
    if (fail_count < 100)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // format one value into its right-aligned text and queue the characters
  function automatic void predict_field(input logic signed [15:0] num,
                                        input logic [3:0] fw, input logic [2:0] fd);
    logic [6:0] text [MAX_FIELD];
    int         total;
    int         wi;
    int         pos;
    int         value;
    int         mag;
    logic       neg;
    logic       dropped;
    total   = int'(fw) + int'(fd);
    wi      = int'(fw);
    value   = int'(num);
    neg     = (value < 0);
    mag     = neg ? -value : value;
    dropped = 1'b0;

    // illegal size collapses to a single error character
    if (fw == 0 || total > MAX_FIELD || (fd != 0 && fw < 2)) begin
      expected_chars.push_back(field_char_t'{code: CH_ERROR, last: 1'b1, ovf: 1'b1});
      return;
    end

    for (int k = 0; k < total; k++)
      text[k] = CH_SPACE;

    // fill digits from the right, point after the fraction, one integer digit minimum
    pos = total - 1;
    while (mag > 0 || pos > wi - 2) begin
      if (pos < 0) begin
        dropped = 1'b1;
        break;
      end
      if (fd != 0 && pos == wi - 1) begin
        text[pos] = CH_POINT;
        pos--;
      end
      text[pos] = CH_ZERO + 7'(mag % 10);
      pos--;
      mag = mag / 10;
    end

    // sign left of the leading digit; a minus with no room counts as overflow
    if (pos >= 0)
      text[pos] = neg ? CH_MINUS : CH_SPACE;
    else if (neg)
      dropped = 1'b1;

    for (int k = 0; k < total; k++)
      expected_chars.push_back(field_char_t'{code: text[k], last: (k == total - 1),
                                             ovf: dropped});
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin : watch
    field_char_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        predict_field(number, field_width, frac_digits);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected character transfer", char_code, 7'h00);
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code)
            report_mismatch("char_code", char_code, want.code);
          if (last_char !== want.last)
            report_mismatch("last_char", 7'(last_char), 7'(want.last));
          if (overflow !== want.ovf)
            report_mismatch("overflow", 7'(overflow), 7'(want.ovf));
        end
      end
      outstanding = expected_chars.size();
    end
  end

endmodule

>>> tb/tb_signed_decimal_field_formatter.sv
// testbench top for the decimal field formatter: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 1ps

module tb_signed_decimal_field_formatter
  import sdf_pkg::*;
();

  localparam int MAX_FIELD    = MAX_FIELD_DEF;
  localparam int RANDOM_ITEMS = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] number;
  logic [3:0]         field_width;
  logic [2:0]         frac_digits;
  logic               out_valid;
  logic               out_ready;
  logic [6:0]         char_code;
  logic               last_char;
  logic               overflow;
  int                 errors;
  int                 chars_outstanding;
  int                 hold_requests = 0;

  always #10 clk = ~clk;

  signed_decimal_field_formatter #(.MAX_FIELD(MAX_FIELD)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .number(number), .field_width(field_width), .frac_digits(frac_digits),
    .out_valid(out_valid), .out_ready(out_ready),
    .char_code(char_code), .last_char(last_char), .overflow(overflow)
  );

  sdf_field_checker #(.MAX_FIELD(MAX_FIELD)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .number(number), .field_width(field_width), .frac_digits(frac_digits),
    .out_valid(out_valid), .out_ready(out_ready),
    .char_code(char_code), .last_char(last_char), .overflow(overflow),
    .errors(errors), .chars_outstanding(chars_outstanding)
  );

  // offer one value until its transfer, called at a falling edge
  task automatic send_field(input int num, input int fw, input int fd);
    in_valid    <= 1'b1;
    number      <= 16'(num);
    field_width <= 4'(fw);
    frac_digits <= 3'(fd);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // values weighted toward extremes, digit-count boundaries and short numbers
  function automatic int pick_number();
    int tens;
    tens = 1;
    case ($urandom_range(0, 5))
      0: return int'($signed(16'($urandom)));
      1: return $urandom_range(0, 198) - 99;
      2: begin
        case ($urandom_range(0, 5))
          0: return -32768;
          1: return 32767;
          2: return -32767;
          3: return 0;
          4: return -1;
          default: return 1;
        endcase
      end
      3: begin
        repeat ($urandom_range(1, 4)) tens = tens * 10;
        tens = tens - $urandom_range(0, 1);
        return $urandom_range(0, 1) ? -tens : tens;
      end
      4: return $urandom_range(0, 1998) - 999;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // stimulus: reset, directed corners, then bursts of random fields
  initial begin : stimulus
    int sent;
    int burst;
    int fw;
    int fd;
    in_valid    = 1'b0;
    number      = '0;
    field_width = '0;
    frac_digits = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners: extremes, fractions, dropped digits, dropped sign, illegal sizes
    send_field(0, 1, 0);
    send_field(-1, 1, 0);
    send_field(32767, 8, 0);
    send_field(-32768, 8, 0);
    send_field(-32768, 6, 0);
    send_field(-32768, 5, 0);
    send_field(32767, 3, 0);
    send_field(-32768, 2, 6);
    send_field(12345, 2, 6);
    send_field(-5, 3, 2);
    send_field(1, 2, 1);
    send_field(100, 4, 1);
    send_field(0, 8, 0);
    send_field(7, 2, 0);
    send_field(-7, 2, 0);
    send_field(-10, 2, 0);
    send_field(16'sh5555, 7, 1);
    send_field(-21846, 6, 2);
    send_field(0, 0, 0);
    send_field(5, 1, 1);
    send_field(5, 8, 1);
    send_field(-3, 9, 0);
    send_field(32767, 15, 7);
    send_field(-1, 2, 7);

    // random fields in bursts, mostly legal sizes
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          fw = $urandom_range(1, MAX_FIELD);
          fd = 0;
          if (fw >= 2 && fw < MAX_FIELD && $urandom_range(0, 1))
            fd = $urandom_range(1, (MAX_FIELD - fw < 7) ? MAX_FIELD - fw : 7);
        end else begin
          fw = $urandom_range(0, 15);
          fd = $urandom_range(0, 7);
        end
        send_field(pick_number(), fw, fd);
        sent++;
        if (sent == 60 || sent == 150)
          hold_requests++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow a few item times for anything stray
    wait (chars_outstanding == 0);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // receiver: segments of ready patterns, plus long hold-offs on request
  initial begin : receiver
    int seg_left;
    int mode;
    int hold_left;
    int holds_done;
    seg_left   = 0;
    mode       = 0;
    hold_left  = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = 300;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= (seg_left % 5 != 0);
        endcase
      end
    end
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
